@@ hdl/ncm_pkg.sv @@
package ncm_pkg;

    // Fixed widths of the sample and phase words.
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int TAB_BITS   = 10;
    localparam int TAB_N      = 1 << TAB_BITS;
    localparam int AMP_W      = SAMPLE_W - 1;
    localparam int AMP_MAX    = (1 << (SAMPLE_W - 1)) - 1;
    localparam int PH_IDX_W   = TAB_BITS + 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // pi/2 in Q2.30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CONJUGATE  = 2'd0,
        CFG_RETUNE_EN  = 2'd1,
        CFG_INIT_FREQ  = 2'd2,
        CFG_INIT_PHASE = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // One queued item: the table index taken from the phase, and the sample.
    typedef struct packed {
        logic [PH_IDX_W-1:0]        phase_idx;
        logic signed [SAMPLE_W-1:0] smp_i;
        logic signed [SAMPLE_W-1:0] smp_q;
    } t_ncm_item;

    // Occupancy flags of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_ncm_qstat;

    typedef logic [AMP_W-1:0] t_sin_tab [0:TAB_N];

    // Quarter-wave sine table, worked out at elaboration from a Q2.30
    // Taylor series of seven terms.
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      s;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (HALF_PI_Q30 * 64'(k) + 64'(TAB_N / 2)) / 64'(TAB_N);
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (64'(s) * 64'(AMP_MAX) + (64'd1 << 29)) >> 30;
            if (v > 64'(AMP_MAX)) begin
                v = 64'(AMP_MAX);
            end
            tab[k] = v[AMP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

@@ hdl/ncm_front.sv @@
module ncm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [ncm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [95:0]                      i_data,
    input  logic [1:0]                       i_user,
    input  ncm_pkg::t_ncm_qstat              i_qstat,
    output logic                             o_push,
    output ncm_pkg::t_ncm_item               o_item
);

    logic                         r_conj;
    logic                         r_retune;
    logic [ncm_pkg::PHASE_W-1:0]  r_inc;
    logic [ncm_pkg::PHASE_W-1:0]  r_acc;
    logic [ncm_pkg::PHASE_W-1:0]  n_inc;
    logic [ncm_pkg::PHASE_W-1:0]  n_acc;
    logic [ncm_pkg::PHASE_W-1:0]  eff_phase;
    logic [ncm_pkg::PHASE_W-1:0]  step;
    logic                         accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign o_push  = accept;

    // With retuning enabled, updates carried by the word take effect before its own sample.
    always_comb begin
        n_inc     = (r_retune && i_user[0]) ? i_data[63:32] : r_inc;
        eff_phase = (r_retune && i_user[1]) ? i_data[95:64] : r_acc;
        step      = r_conj ? (ncm_pkg::PHASE_W'(0) - n_inc) : n_inc;
        n_acc     = eff_phase + step;
    end

    assign o_item.phase_idx = eff_phase[ncm_pkg::PHASE_W-1 -: ncm_pkg::PH_IDX_W];
    assign o_item.smp_i     = signed'(i_data[15:0]);
    assign o_item.smp_q     = signed'(i_data[31:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conj   <= 1'b0;
            r_retune <= 1'b1;
            r_inc    <= '0;
            r_acc    <= '0;
        end else if (i_cfg_wen) begin
            unique case (ncm_pkg::t_cfg_reg'(i_cfg_addr))
                ncm_pkg::CFG_CONJUGATE:  r_conj   <= i_cfg_wdata[0];
                ncm_pkg::CFG_RETUNE_EN:  r_retune <= i_cfg_wdata[0];
                ncm_pkg::CFG_INIT_FREQ:  r_inc    <= i_cfg_wdata[ncm_pkg::PHASE_W-1:0];
                ncm_pkg::CFG_INIT_PHASE: r_acc    <= i_cfg_wdata[ncm_pkg::PHASE_W-1:0];
                default: begin
                end
            endcase
        end else if (accept) begin
            r_inc <= n_inc;
            r_acc <= n_acc;
        end
    end

endmodule

@@ hdl/ncm_queue.sv @@
module ncm_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ncm_pkg::t_ncm_item  i_item,
    input  logic                i_pop,
    output ncm_pkg::t_ncm_item  o_item,
    output ncm_pkg::t_ncm_qstat o_qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ncm_pkg::t_ncm_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_item        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/ncm_back.sv @@
module ncm_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  ncm_pkg::t_ncm_item         i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_data
);

    localparam int SW    = ncm_pkg::SAMPLE_W;
    localparam int PW    = 2 * SW;
    localparam int SUM_W = PW + 1;
    localparam int ADR_W = ncm_pkg::TAB_BITS + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ncm_pkg::AMP_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic                            en;
    logic [ncm_pkg::TAB_BITS-1:0]    lo_addr;
    logic [ADR_W-1:0]                hi_addr;

    // Stage 1: table read.
    logic                            r_s1_valid;
    logic [ncm_pkg::AMP_W-1:0]       r_tab_lo;
    logic [ncm_pkg::AMP_W-1:0]       r_tab_hi;
    ncm_pkg::t_quad                  r_s1_quad;
    logic signed [SW-1:0]            r_s1_i;
    logic signed [SW-1:0]            r_s1_q;

    // Stage 2: products.
    logic                            r_s2_valid;
    logic signed [PW-1:0]            r_p_ic;
    logic signed [PW-1:0]            r_p_qs;
    logic signed [PW-1:0]            r_p_is;
    logic signed [PW-1:0]            r_p_qc;
    logic signed [SW-1:0]            sin_v;
    logic signed [SW-1:0]            cos_v;
    logic signed [SW-1:0]            lo_s;
    logic signed [SW-1:0]            hi_s;

    // Output register.
    logic                            r_out_valid;
    logic signed [SW-1:0]            r_out_i;
    logic signed [SW-1:0]            r_out_q;

    // Rounds half up, floors and clips to the sample range.
    function automatic logic signed [SW-1:0] round_sat(input logic signed [SUM_W-1:0] a);
        logic signed [SUM_W-1:0] rnd;
        logic signed [SUM_W-1:0] sh;
        rnd = a + (SUM_W'(1) << (SW - 2));
        sh  = rnd >>> (SW - 1);
        if (sh > SAT_HI) begin
            return SAT_HI[SW-1:0];
        end else if (sh < SAT_LO) begin
            return SAT_LO[SW-1:0];
        end
        return sh[SW-1:0];
    endfunction

    assign en      = !r_out_valid || i_ready;
    assign o_pop   = en && i_item_valid;
    assign lo_addr = i_item.phase_idx[ncm_pkg::TAB_BITS-1:0];
    assign hi_addr = ADR_W'(ncm_pkg::TAB_N) - {1'b0, lo_addr};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tab_lo  <= ncm_pkg::SIN_TAB[{1'b0, lo_addr}];
            r_tab_hi  <= ncm_pkg::SIN_TAB[hi_addr];
            r_s1_quad <= ncm_pkg::t_quad'(i_item.phase_idx[ncm_pkg::PH_IDX_W-1 -: 2]);
            r_s1_i    <= i_item.smp_i;
            r_s1_q    <= i_item.smp_q;
        end
    end

    always_comb begin
        lo_s = signed'({1'b0, r_tab_lo});
        hi_s = signed'({1'b0, r_tab_hi});
        unique case (r_s1_quad)
            ncm_pkg::QUAD_0: begin
                sin_v = lo_s;
                cos_v = hi_s;
            end
            ncm_pkg::QUAD_1: begin
                sin_v = hi_s;
                cos_v = -lo_s;
            end
            ncm_pkg::QUAD_2: begin
                sin_v = -lo_s;
                cos_v = -hi_s;
            end
            default: begin
                sin_v = -hi_s;
                cos_v = lo_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ic <= r_s1_i * cos_v;
            r_p_qs <= r_s1_q * sin_v;
            r_p_is <= r_s1_i * sin_v;
            r_p_qc <= r_s1_q * cos_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_i <= round_sat(SUM_W'(r_p_ic) - SUM_W'(r_p_qs));
            r_out_q <= round_sat(SUM_W'(r_p_is) + SUM_W'(r_p_qc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_item_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {r_out_q, r_out_i};

endmodule

@@ hdl/nco_complex_mixer.sv @@
// Numerically controlled oscillator and complex mixer. Each complex sample
// arriving on the slave stream is multiplied by exp(j*phase) and the phase
// then advances by the tuning word, negated when conjugate is set.
// The slave word carries the sample and optional tuning and phase updates,
// flagged in tuser; with retuning enabled an update applies to its own
// sample. The master word carries the mixed sample, rounded and clipped.
// Configuration goes through the write port: index 0 conjugate, 1 retune
// enable, 2 tuning word (loads the increment), 3 phase (loads the
// accumulator). Write it only while the block is idle.
// A word passes through the queue and the back pipeline (table read,
// multipliers, rounding). One word is taken every cycle while the queue has
// room; the single phase addition in the front stage is the only recurrence,
// and the back pipeline runs at one word per cycle unless the receiver stalls.
// When the receiver stalls the whole back pipeline holds, the queue fills
// and tready falls once it is full; nothing is lost. Reset empties the queue
// and the pipeline, clears phase and increment, clears conjugate and sets
// retune enable.
module nco_complex_mixer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [ncm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // in_i [15:0], in_q [31:16], new_freq_word [63:32], new_phase_word [95:64]
    input  logic [95:0]                     s_axis_tdata,
    // freq_update_valid [0], phase_update_valid [1]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_i [15:0], out_q [31:16]
    output logic [31:0]                     m_axis_tdata
);

    logic                 q_push;
    logic                 q_pop;
    ncm_pkg::t_ncm_item   front_item;
    ncm_pkg::t_ncm_item   q_item;
    ncm_pkg::t_ncm_qstat  q_stat;

    // Front: takes words, applies updates and steps the phase accumulator.
    ncm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .i_qstat     (q_stat),
        .o_push      (q_push),
        .o_item      (front_item)
    );

    // Short queue that decouples the front from the back pipeline.
    ncm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_qstat (q_stat)
    );

    // Back: sine and cosine lookup, complex multiply, rounding, output register.
    ncm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!q_stat.empty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("master valid set straight after reset");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("word pushed into a full queue");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("word popped from an empty queue");
`endif

endmodule
